### design/smfbs_pkg.sv
package smfbs_pkg;

    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 32;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 10;
    localparam int VAL_W     = 32;
    localparam int IN_DATA_W  = 48;   // position + value, padded to bytes
    localparam int OUT_DATA_W = 8;
    // signed window bounds; lo + hi of the largest window must not overflow
    localparam int WIN_W = 2 * CFG_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic load;     // write one element
        logic start;    // capture search target
        logic setup;    // open window, issue first read
        logic probe;    // compare and narrow
        logic commit;   // move answer to output register
    } cmd_t;

    typedef struct packed {
        logic empty;      // window empty at setup
        logic hit;        // probed element equals target
        logic exhausted;  // window empty after narrowing
    } status_t;

endpackage

### design/smfbs_ram.sv
module smfbs_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/smfbs_datapath.sv
module smfbs_datapath
    import smfbs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [POS_W-1:0]       position,
    input  logic signed [VAL_W-1:0] value,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   found
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [WIN_W-1:0] ONE = WIN_W'(1);

    logic [CFG_W-1:0]         row_count_reg;
    logic [CFG_W-1:0]         column_count_reg;
    logic signed [VAL_W-1:0]  target_reg;
    logic signed [WIN_W-1:0]  lo_reg;
    logic signed [WIN_W-1:0]  hi_reg;
    logic signed [WIN_W-1:0]  mid_reg;
    logic                     hit_reg;
    logic                     found_reg;

    logic [WIN_W-1:0]         rows_ext;
    logic [WIN_W-1:0]         cols_ext;
    logic [CFG_W-1:0]         rows_sat;
    logic [CFG_W-1:0]         cols_sat;
    logic [2*CFG_W-1:0]       cell_count;
    logic signed [WIN_W-1:0]  hi_init;
    logic signed [WIN_W-1:0]  lo_next;
    logic signed [WIN_W-1:0]  hi_next;
    logic signed [WIN_W-1:0]  sum_next;
    logic signed [WIN_W-1:0]  mid_next;
    logic signed [WIN_W-1:0]  mid_issue;
    logic signed [VAL_W-1:0]  elem;
    logic                     elem_lt;
    logic                     ram_we;
    logic [ADDR_W-1:0]        raddr;
    logic [VAL_W-1:0]         rdata;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(1);
            column_count_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                REG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // saturate to the store geometry, result always fits the register width
    assign rows_ext = WIN_W'(row_count_reg);
    assign cols_ext = WIN_W'(column_count_reg);
    assign rows_sat = (rows_ext > WIN_W'(MAX_ROWS))    ? CFG_W'(MAX_ROWS)    : row_count_reg;
    assign cols_sat = (cols_ext > WIN_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : column_count_reg;
    assign cell_count = (2*CFG_W)'(rows_sat) * (2*CFG_W)'(cols_sat);
    assign hi_init    = signed'(WIN_W'(cell_count)) - ONE;

    // probe step
    assign elem     = signed'(rdata);
    assign elem_lt  = elem < target_reg;
    assign lo_next  = elem_lt ? (mid_reg + ONE) : lo_reg;
    assign hi_next  = elem_lt ? hi_reg : (mid_reg - ONE);
    assign sum_next = lo_next + hi_next;
    assign mid_next = sum_next >>> 1;

    // setup issues the middle of the full window, probe the middle of the narrowed one
    assign mid_issue = cmd.setup ? (hi_init >>> 1) : mid_next;
    assign raddr     = ADDR_W'(unsigned'(mid_issue));

    assign ram_we = cmd.load && (32'(position) < DEPTH);

    smfbs_ram
    #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    )
    u_store
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(position)),
        .wdata (unsigned'(value)),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            target_reg <= value;
        end
        if (cmd.setup)
        begin
            lo_reg  <= '0;
            hi_reg  <= hi_init;
            mid_reg <= hi_init >>> 1;
            hit_reg <= 1'b0;
        end
        else if (cmd.probe)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
            hit_reg <= (elem == target_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            found_reg <= hit_reg;
        end
    end

    assign status.empty     = (cell_count == '0);
    assign status.hit       = (elem == target_reg);
    assign status.exhausted = lo_next > hi_next;
    assign found            = found_reg;

endmodule

### design/smfbs_ctrl.sv
module smfbs_ctrl
    import smfbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_mode,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_PROBE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.empty ? ST_FINISH : ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.hit || status.exhausted)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/sorted_matrix_flat_binary_search.sv
// Membership search over a row-major matrix of signed 32-bit elements held
// in an on-chip store of MAX_ROWS*MAX_COLUMNS words. A load item (tuser = 0)
// writes one element at its flat position and gives no result; positions at
// or beyond the store depth are dropped. A search item (tuser = 1) runs a
// binary search over flat indices 0 .. rows*cols-1 and returns one item
// whose bit 0 is found. Elements must be loaded in ascending order, and every
// position inside the window must be written before it is searched.
// Loads are taken back to back whenever the block is idle; a search holds off
// input from acceptance until its result is committed. It makes P probes, P at most
// ceil(log2(rows*cols + 1)), 11 for a 32x32 matrix; each probe is one read
// of the store's single registered read port. A finished result sits in the
// output register, and loads are taken while it waits.
module sorted_matrix_flat_binary_search
    import smfbs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // position[9:0], value[41:10]
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found[0]
);

    cmd_t    cmd;
    status_t status;
    logic    found;

    smfbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    smfbs_datapath
    #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .position  (s_tdata[POS_W-1:0]),
        .value     (signed'(s_tdata[POS_W+VAL_W-1:POS_W])),
        .cmd       (cmd),
        .status    (status),
        .found     (found)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, found};

`ifndef ASSERT_OFF
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_SEARCH) |=> !s_tready)
        else $error("search accepted but block still ready");

    a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.probe && status.hit) |=> !cmd.probe)
        else $error("probing continued after a hit");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.start, cmd.setup, cmd.probe, cmd.commit}))
        else $error("conflicting datapath commands");
`endif

endmodule
